// File: rtl/assert_macros.svh
// Assertion macros for the RTL modules; cpas_ctrl is the one that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: %m");

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: rtl/cpas_pkg.sv
// Types, constants and prefix compare functions of the prefix aggregation stack.
`default_nettype none

package cpas_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned TGT_W       = 16;
  localparam int unsigned ADDR_W      = 128;

  localparam logic [LEN_W-1:0] MAX_LEN  = 8'd128;
  localparam logic             REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_HOST_CLEARED = 2'd2,
    STATUS_BAD_INDEX    = 2'd3
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [63:0]      addr_high;
    logic [63:0]      addr_low;
    logic [LEN_W-1:0] prefix_len;
    logic [TGT_W-1:0] target_id;
    logic [9:0]       read_index;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       status;
    logic [CNT_W-1:0] merges_done;
    logic [63:0]      out_addr_high;
    logic [63:0]      out_addr_low;
    logic [LEN_W-1:0] out_prefix_len;
    logic [TGT_W-1:0] out_target_id;
  } rsp_t;

  typedef struct packed {
    logic [63:0]      addr_high;
    logic [63:0]      addr_low;
    logic [LEN_W-1:0] prefix_len;
    logic [TGT_W-1:0] target_id;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

  // Mask of the leading n address bits; n is at most 128.
  function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] n);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    if (n == '0) begin
      return '0;
    end
    return ones << (MAX_LEN - n);
  endfunction

  function automatic logic lead_equal(input entry_t a, input entry_t b,
                                      input logic [LEN_W-1:0] n);
    logic [ADDR_W-1:0] diff;
    diff = {a.addr_high, a.addr_low} ^ {b.addr_high, b.addr_low};
    return (diff & lead_mask(n)) == '0;
  endfunction

  // Merge decision for the older entry a and the newer entry b.
  function automatic logic can_merge(input entry_t a, input entry_t b);
    logic res;
    res = 1'b0;
    if (a.target_id == b.target_id) begin
      if (a.prefix_len == b.prefix_len) begin
        if (a.prefix_len == '0) begin
          res = 1'b1;
        end else begin
          res = lead_equal(a, b, a.prefix_len - 8'd1);
        end
      end else if (a.prefix_len < b.prefix_len) begin
        res = lead_equal(a, b, a.prefix_len);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cpas_store.sv
// Entry memory of the prefix stack with one registered read and one write.
`default_nettype none

module cpas_store (
  input  logic                clk_i,
  input  cpas_pkg::mem_req_t  mem_req_i,
  output cpas_pkg::entry_t    rdata_o
);
  import cpas_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem[mem_req_i.addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.rd_en) begin
      rdata_q <= mem[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/cpas_ctrl.sv
// Request sequencer, merge loop and result register of the prefix stack.
`default_nettype none

`include "assert_macros.svh"

module cpas_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               normalized_mode_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpas_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpas_pkg::rsp_t     out_data_o,
  output cpas_pkg::mem_req_t mem_req_o,
  input  cpas_pkg::entry_t   mem_rdata_i
);
  import cpas_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] merges_q, merges_d;
  status_e          status_q, status_d;
  logic             rd_q, rd_d;
  entry_t           b_q, b_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic [LEN_W-1:0]  len_sat;
  logic [ADDR_W-1:0] in_mask;
  logic [ADDR_W-1:0] in_addr;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_m2;
  logic              read_ok;
  entry_t            merged;

  assign len_sat  = (in_data_i.prefix_len > MAX_LEN) ? MAX_LEN : in_data_i.prefix_len;
  assign in_mask  = lead_mask(len_sat);
  assign in_addr  = {in_data_i.addr_high, in_data_i.addr_low};
  assign count_m1 = count_q - 1'b1;
  assign idx_m1   = idx_q - 1'b1;
  assign idx_m2   = idx_q - 2'd2;
  assign read_ok  = rd_q && (status_q == STATUS_OK);

  always_comb begin
    merged = mem_rdata_i;
    if ((mem_rdata_i.prefix_len == b_q.prefix_len) && (mem_rdata_i.prefix_len != '0)) begin
      merged.prefix_len = mem_rdata_i.prefix_len - 8'd1;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    merges_d    = merges_q;
    status_d    = status_q;
    rd_d        = rd_q;
    b_d         = b_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_req_o.rd_en = 1'b0;
    mem_req_o.wr_en = 1'b0;
    mem_req_o.addr  = idx_q[IDX_W-1:0];
    mem_req_o.wdata = b_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          merges_d = '0;
          status_d = STATUS_OK;
          rd_d     = (in_data_i.req_type == REQ_READ);
          idx_d    = count_q;
          state_d  = S_DONE;
          if (in_data_i.req_type == REQ_READ) begin
            if (CNT_W'(in_data_i.read_index) < count_q) begin
              mem_req_o.rd_en = 1'b1;
              mem_req_o.addr  = in_data_i.read_index[IDX_W-1:0];
            end else begin
              status_d = STATUS_BAD_INDEX;
            end
          end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
            status_d = STATUS_FULL;
          end else begin
            b_d.addr_high  = in_data_i.addr_high;
            b_d.addr_low   = in_data_i.addr_low;
            b_d.prefix_len = len_sat;
            b_d.target_id  = in_data_i.target_id;
            if (!normalized_mode_i) begin
              {b_d.addr_high, b_d.addr_low} = in_addr & in_mask;
              if ((in_addr & ~in_mask) != '0) begin
                status_d = STATUS_HOST_CLEARED;
              end
            end
            if (!normalized_mode_i || (count_q == '0)) begin
              state_d = S_WRITE;
            end else begin
              mem_req_o.rd_en = 1'b1;
              mem_req_o.addr  = count_m1[IDX_W-1:0];
              state_d         = S_CMP;
            end
          end
        end
      end
      S_CMP: begin
        if (can_merge(mem_rdata_i, b_q)) begin
          b_d      = merged;
          idx_d    = idx_m1;
          merges_d = merges_q + 1'b1;
          if (idx_m1 != '0) begin
            mem_req_o.rd_en = 1'b1;
            mem_req_o.addr  = idx_m2[IDX_W-1:0];
          end else begin
            state_d = S_WRITE;
          end
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_req_o.wr_en = 1'b1;
        count_d         = idx_q + 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.entry_count    = count_q;
          out_d.status         = status_q;
          out_d.merges_done    = merges_q;
          out_d.out_addr_high  = read_ok ? mem_rdata_i.addr_high : '0;
          out_d.out_addr_low   = read_ok ? mem_rdata_i.addr_low : '0;
          out_d.out_prefix_len = read_ok ? mem_rdata_i.prefix_len : '0;
          out_d.out_target_id  = read_ok ? mem_rdata_i.target_id : '0;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    merges_q <= merges_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    b_q      <= b_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_ENTRIES))
  `ASSERT_IMPLIES(a_cmp_index, clk_i, rst_ni, state_q == S_CMP,
                  (idx_q != '0) && (idx_q <= count_q))
  `ASSERT_IMPLIES(a_merge_balance, clk_i, rst_ni, (state_q == S_CMP) || (state_q == S_WRITE),
                  ({1'b0, idx_q} + {1'b0, merges_q}) == {1'b0, count_q})
  `ASSERT_ALWAYS(a_mem_port, clk_i, rst_ni, !(mem_req_o.rd_en && mem_req_o.wr_en))

endmodule

`default_nettype wire

// File: rtl/cidr_prefix_aggregation_stack.sv
// Append: S_IDLE, merge walk in S_CMP (normalized mode, non-empty stack), S_WRITE, then S_DONE.
// A dropped append and a read go from S_IDLE straight to S_DONE, which loads the output register.
// The merge walk is paced by the single-port entry memory: one read and compare per cycle.
// A new request is taken once the previous result is in the output register.
// Reset clears the entry count and sets normalized mode; entries stay undefined, no clearing pass.
`default_nettype none

module cidr_prefix_aggregation_stack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpas_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cpas_pkg::rsp_t   out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);
  import cpas_pkg::*;

  logic     normalized_mode_q;
  mem_req_t mem_req;
  entry_t   mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normalized_mode_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      normalized_mode_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  cpas_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  cpas_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .normalized_mode_i (normalized_mode_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_o        (out_data_o),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata)
  );

endmodule

`default_nettype wire

// File: tb/prefix_stack_monitor.sv
// Monitor that predicts every response of the prefix aggregation stack and compares it.
`timescale 1ns / 1ps

module prefix_stack_monitor (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  cpas_pkg::req_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  cpas_pkg::rsp_t  out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic            cfg_data_i,
  output int              mismatches_o,
  output int              outstanding_o,
  output int              stored_o
);
  import cpas_pkg::*;

  logic [63:0]      tbl_high [MAX_ENTRIES];
  logic [63:0]      tbl_low  [MAX_ENTRIES];
  logic [LEN_W-1:0] tbl_len  [MAX_ENTRIES];
  logic [TGT_W-1:0] tbl_tgt  [MAX_ENTRIES];

  int unsigned depth = 0;
  bit          merge_on = 1'b1;
  int          mismatches = 0;
  int          pending = 0;
  rsp_t        expected_rsp_q [$];

  assign mismatches_o  = mismatches;
  assign outstanding_o = pending;
  assign stored_o      = depth;

  function automatic logic [ADDR_W-1:0] net_mask(input int unsigned n);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    if (n == 0) begin
      return '0;
    end
    return ones << (ADDR_W - n);
  endfunction

  function automatic bit same_lead(input int unsigned a, input int unsigned b,
                                   input int unsigned n);
    logic [ADDR_W-1:0] diff;
    diff = {tbl_high[a], tbl_low[a]} ^ {tbl_high[b], tbl_low[b]};
    return (diff & net_mask(n)) == '0;
  endfunction

  function automatic bit mergeable(input int unsigned older, input int unsigned newer);
    int unsigned la;
    int unsigned lb;
    la = {24'd0, tbl_len[older]};
    lb = {24'd0, tbl_len[newer]};
    if (tbl_tgt[older] != tbl_tgt[newer]) begin
      return 1'b0;
    end
    if (la == lb) begin
      return (la == 0) || same_lead(older, newer, la - 1);
    end
    return (la < lb) && same_lead(older, newer, la);
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t              res;
    int unsigned       len;
    int unsigned       top;
    int unsigned       merged;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] keep;
    res = '0;
    merged = 0;
    res.status = STATUS_OK;
    if (r.req_type == REQ_READ) begin
      if (r.read_index < depth) begin
        res.out_addr_high  = tbl_high[r.read_index];
        res.out_addr_low   = tbl_low[r.read_index];
        res.out_prefix_len = tbl_len[r.read_index];
        res.out_target_id  = tbl_tgt[r.read_index];
      end else begin
        res.status = STATUS_BAD_INDEX;
      end
    end else if (depth >= MAX_ENTRIES) begin
      res.status = STATUS_FULL;
    end else begin
      len = (r.prefix_len > MAX_LEN) ? {24'd0, MAX_LEN} : {24'd0, r.prefix_len};
      addr = {r.addr_high, r.addr_low};
      if (!merge_on) begin
        keep = net_mask(len);
        if ((addr & ~keep) != '0) begin
          res.status = STATUS_HOST_CLEARED;
        end
        addr = addr & keep;
      end
      top = depth;
      tbl_high[top] = addr[127:64];
      tbl_low[top]  = addr[63:0];
      tbl_len[top]  = len[LEN_W-1:0];
      tbl_tgt[top]  = r.target_id;
      depth = depth + 1;
      if (merge_on) begin
        while (top > 0 && mergeable(top - 1, top)) begin
          if (tbl_len[top-1] == tbl_len[top] && tbl_len[top-1] != '0) begin
            tbl_len[top-1] = tbl_len[top-1] - 8'd1;
          end
          depth = depth - 1;
          merged = merged + 1;
          top = top - 1;
        end
      end
    end
    res.entry_count = depth[CNT_W-1:0];
    res.merges_done = merged[CNT_W-1:0];
    return res;
  endfunction

  function automatic void report(input string what, input rsp_t want, input rsp_t got);
    mismatches = mismatches + 1;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected count=%0d status=%0d merges=%0d addr=%h_%h len=%0d target=%h",
               want.entry_count, want.status, want.merges_done, want.out_addr_high,
               want.out_addr_low, want.out_prefix_len, want.out_target_id);
      $display("  actual   count=%0d status=%0d merges=%0d addr=%h_%h len=%0d target=%h",
               got.entry_count, got.status, got.merges_done, got.out_addr_high,
               got.out_addr_low, got.out_prefix_len, got.out_target_id);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      depth = 0;
      merge_on = 1'b1;
      pending = 0;
      expected_rsp_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        merge_on = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_rsp_q.push_back(apply_request(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report("response transaction with no request outstanding", '0, out_data_i);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_data_i.entry_count !== want.entry_count ||
              out_data_i.status !== want.status ||
              out_data_i.merges_done !== want.merges_done ||
              out_data_i.out_addr_high !== want.out_addr_high ||
              out_data_i.out_addr_low !== want.out_addr_low ||
              out_data_i.out_prefix_len !== want.out_prefix_len ||
              out_data_i.out_target_id !== want.out_target_id) begin
            report("response field mismatch", want, out_data_i);
          end
        end
      end
      pending = expected_rsp_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top level that drives prefix appends, reads and mode writes into the aggregation stack.
`timescale 1ns / 1ps

module testbench;
  import cpas_pkg::*;

  localparam logic REQ_APPEND = 1'b0;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  int mon_mismatches;
  int mon_outstanding;
  int mon_stored;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  cidr_prefix_aggregation_stack DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  prefix_stack_monitor monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mon_mismatches),
    .outstanding_o (mon_outstanding),
    .stored_o      (mon_stored)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_target();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 12) begin
      return 16'($urandom_range(3));
    end
    if (r < 14) begin
      return 16'hFFFF;
    end
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_len();
    if ($urandom_range(7) == 0) begin
      return 8'($urandom_range(129, 255));
    end
    return 8'($urandom_range(128));
  endfunction

  function automatic req_t make_append(input logic [127:0] a, input logic [7:0] len,
                                       input logic [15:0] tgt);
    req_t r;
    r.req_type   = REQ_APPEND;
    r.addr_high  = a[127:64];
    r.addr_low   = a[63:0];
    r.prefix_len = len;
    r.target_id  = tgt;
    r.read_index = 10'($urandom);
    return r;
  endfunction

  function automatic req_t make_read(input logic [9:0] idx);
    req_t r;
    r.req_type   = REQ_READ;
    r.addr_high  = rand64();
    r.addr_low   = rand64();
    r.prefix_len = 8'($urandom);
    r.target_id  = 16'($urandom);
    r.read_index = idx;
    return r;
  endfunction

  task automatic push_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (mon_outstanding != 0) begin
      @(negedge clk_i);
    end
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_read();
    if ($urandom_range(1) == 0) begin
      push_request(make_read(10'($urandom_range(63))));
    end else begin
      push_request(make_read(10'($urandom_range(1023))));
    end
  endtask

  // Each subprefix of one random block, ascending; stray targets and extras mixed in.
  task automatic send_block();
    int unsigned  d;
    int unsigned  base_len;
    int unsigned  sub_len;
    int unsigned  k;
    logic [127:0] base;
    logic [127:0] sub;
    logic [127:0] kk;
    logic [127:0] low_bits;
    logic [15:0]  tgt;
    d = $urandom_range(1, 4);
    base_len = $urandom_range(0, 128 - d);
    sub_len = base_len + d;
    base = {rand64(), rand64()};
    base = (base >> (128 - base_len)) << (128 - base_len);
    low_bits = (128'd1 << (128 - sub_len)) - 128'd1;
    tgt = pick_target();
    for (k = 0; k < (1 << d); k++) begin
      kk = 128'(k);
      sub = base | (kk << (128 - sub_len)) | ({rand64(), rand64()} & low_bits);
      if ($urandom_range(11) == 0) begin
        push_request(make_append(sub, 8'(sub_len), pick_target()));
      end else begin
        push_request(make_append(sub, 8'(sub_len), tgt));
      end
      if (k == 0 && sub_len < 128 && $urandom_range(3) == 0) begin
        push_request(make_append(sub ^ ({rand64(), rand64()} & low_bits),
                                 8'($urandom_range(sub_len + 1, 128)), tgt));
      end
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(99) < 35) begin
      send_read();
    end else begin
      push_request(make_append({rand64(), rand64()}, pick_len(), pick_target()));
    end
  endtask

  task automatic send_raw_append();
    logic [127:0] a;
    logic [7:0]   len;
    len = pick_len();
    a = {rand64(), rand64()};
    if ($urandom_range(1) == 0) begin
      a = (len >= 128) ? a : ((a >> (128 - len)) << (128 - len));
    end
    push_request(make_append(a, len, pick_target()));
  endtask

  task automatic directed_checks();
    logic [127:0] ones;
    logic [63:0]  hi;
    ones = '1;
    hi = 64'h0123_4567_89AB_CDEF;
    push_request(make_read(10'd0));
    push_request(make_append(ones, 8'd128, 16'hFFFF));
    push_request(make_append(ones ^ 128'd1, 8'd128, 16'hFFFF));
    push_request(make_append(ones, 8'd255, 16'hFFFF));
    push_request(make_append('0, 8'd0, 16'd5));
    push_request(make_append({rand64(), rand64()}, 8'd0, 16'd5));
    push_request(make_append({64'h8000_0000_0000_0000, 64'd0}, 8'd1, 16'd5));
    push_request(make_append({hi, rand64()}, 8'd64, 16'd7));
    push_request(make_append({hi ^ 64'd1, rand64()}, 8'd64, 16'd7));
    push_request(make_append({~hi, 64'd0}, 8'd65, 16'd9));
    push_request(make_append({~hi, 64'h8000_0000_0000_0000}, 8'd65, 16'd9));
    push_request(make_append({2'b00, 62'd0, 64'd0}, 8'd2, 16'd3));
    push_request(make_append({2'b01, 62'd0, 64'd0}, 8'd2, 16'd3));
    push_request(make_append({2'b10, 62'd0, 64'd0}, 8'd2, 16'd3));
    push_request(make_append({2'b11, 62'd0, 64'd0}, 8'd2, 16'd3));
    push_request(make_append({2'b11, 62'd0, 64'd0}, 8'd2, 16'd4));
    push_request(make_read(10'd0));
    push_request(make_read(10'd5));
    push_request(make_read(10'd6));
    push_request(make_read(10'h3FF));
    write_mode(1'b0);
    push_request(make_append(ones, 8'd0, 16'd0));
    push_request(make_append(ones, 8'd128, 16'd1));
    push_request(make_append(ones, 8'd200, 16'd2));
    push_request(make_append({64'd0, 64'd1}, 8'd127, 16'd3));
    push_request(make_read(10'd7));
    write_mode(1'b1);
  endtask

  initial begin
    int room;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 52;
    directed_checks();
    while (sent < 200) begin
      if ($urandom_range(99) < 70) begin
        send_block();
      end else begin
        send_noise();
      end
    end

    write_mode(1'b0);
    send_idle_pct = 52;
    recv_idle_pct = 17;
    while (sent < 400) begin
      if ($urandom_range(99) < 30) begin
        send_read();
      end else begin
        send_raw_append();
      end
    end

    write_mode(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent < 500) begin
      if ($urandom_range(99) < 70) begin
        send_block();
      end else begin
        send_noise();
      end
    end

    // Raw appends never merge, so the store fills up with one entry per append.
    write_mode(1'b0);
    room = MAX_ENTRIES - mon_stored;
    repeat (room) begin
      send_raw_append();
      if ($urandom_range(9) == 0) begin
        push_request(make_read(10'($urandom_range(1023))));
      end
    end
    push_request(make_read(10'h3FF));
    push_request(make_read(10'd0));
    repeat (30) begin
      if ($urandom_range(1) == 0) begin
        push_request(make_read(10'($urandom_range(1023))));
      end else begin
        send_raw_append();
      end
    end

    write_mode(1'b1);
    repeat (6) send_block();
    repeat (10) send_read();

    settle();
    if (mon_mismatches == 0 && mon_outstanding == 0) begin
      $display("PASS cidr_prefix_aggregation_stack");
    end else begin
      $display("FAIL cidr_prefix_aggregation_stack");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL cidr_prefix_aggregation_stack");
    $finish;
  end

endmodule
